FILE: design/oscc_pkg.sv
// shared types and constants for the obstacle segment collision check
`timescale 1ns / 1ps
`default_nettype none
package oscc_pkg;
  localparam int MAX_OBSTACLES = 16;
  localparam int IDX_W = $clog2(MAX_OBSTACLES);
  localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);
  localparam int T_FRAC_BITS = 16;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_QUERY  = 2'd3;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_HIT    = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        r;
  } obstacle_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       load;      // capture input beat
    logic       rd;        // read entry at rd_addr
    logic [IDX_W-1:0] rd_addr;
    logic       wr;        // write entry
    logic [IDX_W-1:0] wr_addr;
    logic       wr_shift;  // write data comes from last read
    logic       geo;       // compute dot/len terms on read entry
    logic       div_start;
    logic       pt;        // compute the clamped projection parameter t
    logic       scale;     // segment scaled by t
    logic       cmp;       // final compare
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic hit;
  } dp_stat_t;
endpackage
`default_nettype wire

FILE: design/oscc_div.sv
// restoring divider for the projection parameter, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module oscc_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [33:0] num,   // dividend, below den
  input  wire logic [33:0] den,
  output logic             busy,
  output logic [oscc_pkg::T_FRAC_BITS:0] quo
);
  localparam int QW = oscc_pkg::T_FRAC_BITS;
  localparam int CW = $clog2(QW + 1);
  logic [34:0] rem;
  logic [33:0] dv;
  logic [CW-1:0] cnt;
  logic [35:0] trial;

  // shift in one quotient bit per cycle
  assign trial = {rem, 1'b0} - {2'b00, dv};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(QW);
      rem  <= {1'b0, num};
      dv   <= den;
      quo  <= '0;
    end else if (busy) begin
      if (!trial[35]) begin
        rem <= trial[34:0];
        quo <= {quo[QW-1:0], 1'b1};
      end else begin
        rem <= {rem[33:0], 1'b0};
        quo <= {quo[QW-1:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

FILE: design/oscc_datapath.sv
// datapath: obstacle memory, projection arithmetic and distance compare
`timescale 1ns / 1ps
`default_nettype none
module oscc_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire oscc_pkg::dp_cmd_t  cmd,
  output oscc_pkg::dp_stat_t      stat,
  input  wire logic signed [15:0] obs_x,
  input  wire logic signed [15:0] obs_y,
  input  wire logic [14:0]        obs_radius,
  input  wire logic signed [15:0] start_x,
  input  wire logic signed [15:0] start_y,
  input  wire logic signed [15:0] end_x,
  input  wire logic signed [15:0] end_y,
  input  wire logic [14:0]        margin,
  output oscc_pkg::obstacle_t     cur,
  output logic signed [15:0]      px16,
  output logic signed [15:0]      py16
);
  localparam int TF = oscc_pkg::T_FRAC_BITS;
  oscc_pkg::obstacle_t mem [oscc_pkg::MAX_OBSTACLES];
  oscc_pkg::obstacle_t in_obs;
  logic signed [16:0] sx, sy, abx, aby;
  logic signed [34:0] len;
  logic signed [35:0] dot;
  logic signed [35:0] dot_sum;
  logic signed [34:0] mx, my;
  logic signed [TF+1:0] t;
  logic signed [TF+18:0] tx, ty;
  logic signed [17:0] px, py;
  logic signed [18:0] dx, dy;
  logic [37:0] d2a, d2b;
  logic [15:0] lim;
  logic [TF:0] quo;
  logic hit;
  logic div_busy;
  logic [33:0] dot_lo;

  // entry memory, one read and one write port
  always_ff @(posedge clk) begin
    if (cmd.wr) mem[cmd.wr_addr] <= cmd.wr_shift ? cur : in_obs;
    if (cmd.rd) cur <= mem[cmd.rd_addr];
  end

  // capture the item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_obs <= '{x: obs_x, y: obs_y, r: obs_radius};
      sx  <= 17'(start_x);
      sy  <= 17'(start_y);
      abx <= 17'(end_x) - 17'(start_x);
      aby <= 17'(end_y) - 17'(start_y);
    end
  end

  // dot product feeds the divider in the cycle it starts
  assign dot_sum = 36'(mx) + 36'(my);
  assign dot_lo = dot_sum[33:0];

  oscc_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .num(dot_lo), .den(len[33:0]), .busy(div_busy), .quo(quo)
  );

  // projection, closest point and distance in registered steps
  always_ff @(posedge clk) begin
    if (cmd.geo) begin
      mx  <= (35'(cur.x) - 35'(sx)) * 35'(abx);
      my  <= (35'(cur.y) - 35'(sy)) * 35'(aby);
      len <= 35'(abx) * 35'(abx) + 35'(aby) * 35'(aby);
      lim <= 16'(cur.r) + 16'(margin);
    end
    if (cmd.div_start) dot <= dot_sum;
    if (cmd.pt) begin
      if (len == 0 || dot <= 0) t <= '0;
      else if (dot >= 36'(len)) t <= (TF+2)'(1) <<< TF;
      else t <= (TF+2)'(quo);
    end
    if (cmd.scale) begin
      tx <= t * (TF+19)'(abx);
      ty <= t * (TF+19)'(aby);
    end
    if (cmd.cmp) begin
      d2a <= 38'(dx) * 38'(dx);
      d2b <= 38'(dy) * 38'(dy);
    end
  end

  assign px = 18'(sx) + 18'(tx >>> TF);
  assign py = 18'(sy) + 18'(ty >>> TF);
  assign dx = 19'(px) - 19'(cur.x);
  assign dy = 19'(py) - 19'(cur.y);
  assign px16 = px[15:0];
  assign py16 = py[15:0];
  assign hit = (d2a + d2b) < 38'(32'(lim) * 32'(lim));
  assign stat = '{div_busy: div_busy, hit: hit};
endmodule
`default_nettype wire

FILE: design/oscc_ctrl.sv
// controller: sequences table edits and the query walk
`timescale 1ns / 1ps
`default_nettype none
module oscc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        kind,
  input  wire logic [7:0]        remove_index,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             status,
  output logic [7:0]             hit_index,
  output logic                   hit_sel,
  output logic [8:0]             table_count,
  output oscc_pkg::dp_cmd_t      cmd,
  input  wire oscc_pkg::dp_stat_t stat
);
  localparam int IW = oscc_pkg::IDX_W;
  localparam int CW = oscc_pkg::CNT_W;
  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_SHRD, S_SHWR, S_QRD, S_QGEO, S_QDIV, S_QWAIT, S_QPT, S_QDST,
    S_QCMP, S_QCHK, S_OUT
  } state_t;
  state_t state;
  logic [CW-1:0] count;
  logic [IW:0] idx;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign table_count = 9'(count);

  // command decode
  always_comb begin
    cmd = '0;
    cmd.load = in_valid && in_ready;
    cmd.rd_addr = idx[IW-1:0];
    cmd.wr_addr = (state == S_ADD) ? count[IW-1:0] : IW'(idx - 1'b1);
    cmd.wr = (state == S_ADD) || (state == S_SHWR);
    cmd.wr_shift = (state == S_SHWR);
    cmd.rd = (state == S_SHRD) || (state == S_QRD);
    cmd.geo = (state == S_QGEO);
    cmd.div_start = (state == S_QDIV);
    cmd.pt = (state == S_QPT);
    cmd.scale = (state == S_QDST);
    cmd.cmp = (state == S_QCMP);
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          status <= oscc_pkg::ST_DONE;
          hit_index <= '0;
          hit_sel <= 1'b0;
          unique case (kind)
            oscc_pkg::KIND_ADD: begin
              if (count == CW'(oscc_pkg::MAX_OBSTACLES)) begin
                status <= oscc_pkg::ST_REJECT;
                state <= S_OUT;
              end else state <= S_ADD;
            end
            oscc_pkg::KIND_REMOVE: begin
              if (9'(remove_index) >= 9'(count)) begin
                status <= oscc_pkg::ST_REJECT;
                state <= S_OUT;
              end else begin
                idx <= (IW+1)'(remove_index) + 1'b1;
                state <= S_SHRD;
              end
            end
            oscc_pkg::KIND_CLEAR: begin
              count <= '0;
              state <= S_OUT;
            end
            default: begin
              idx <= '0;
              state <= (count == 0) ? S_OUT : S_QRD;
            end
          endcase
        end
        S_ADD: begin
          count <= count + 1'b1;
          state <= S_OUT;
        end
        S_SHRD: begin
          if ((IW+1)'(idx) >= (IW+1)'(count)) begin
            count <= count - 1'b1;
            state <= S_OUT;
          end else state <= S_SHWR;
        end
        S_SHWR: begin
          idx <= idx + 1'b1;
          state <= S_SHRD;
        end
        S_QRD:   state <= S_QGEO;
        S_QGEO:  state <= S_QDIV;
        S_QDIV:  state <= S_QWAIT;
        S_QWAIT: if (!stat.div_busy) state <= S_QPT;
        S_QPT:   state <= S_QDST;
        S_QDST:  state <= S_QCMP;
        S_QCMP:  state <= S_QCHK;
        S_QCHK: begin
          if (stat.hit) begin
            status <= oscc_pkg::ST_HIT;
            hit_index <= 8'(idx);
            hit_sel <= 1'b1;
            state <= S_OUT;
          end else if ((IW+1)'(idx) + 1'b1 >= (IW+1)'(count)) state <= S_OUT;
          else begin
            idx <= idx + 1'b1;
            state <= S_QRD;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: design/obstacle_segment_collision_check.sv
// top level: obstacle table with segment collision query
// query: the 16-step divider runs once per obstacle examined
// one item at a time; a new beat is taken once the previous result is taken
// rst (synchronous) empties the table and clears the margin register
`timescale 1ns / 1ps
`default_nettype none
module obstacle_segment_collision_check (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic signed [15:0] obs_x,
  input  wire logic signed [15:0] obs_y,
  input  wire logic [14:0] obs_radius,
  input  wire logic [7:0]  remove_index,
  input  wire logic signed [15:0] start_x,
  input  wire logic signed [15:0] start_y,
  input  wire logic signed [15:0] end_x,
  input  wire logic signed [15:0] end_y,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [7:0]       hit_index,
  output logic signed [15:0] hit_x,
  output logic signed [15:0] hit_y,
  output logic [14:0]      hit_radius,
  output logic signed [15:0] closest_x,
  output logic signed [15:0] closest_y,
  output logic [8:0]       table_count
);
  logic [14:0] margin_reg;
  oscc_pkg::dp_cmd_t cmd;
  oscc_pkg::dp_stat_t stat;
  oscc_pkg::obstacle_t cur;
  logic signed [15:0] px, py;
  logic hit_sel;
  logic [15:0] hx, hy, cx, cy;
  logic [14:0] hr;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {17'd0, margin_reg} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) margin_reg <= '0;
    else if (psel && penable && pwrite && paddr == 2'd0) margin_reg <= pwdata[14:0];
  end

  oscc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
    .remove_index(remove_index), .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .hit_index(hit_index), .hit_sel(hit_sel),
    .table_count(table_count), .cmd(cmd), .stat(stat)
  );

  oscc_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .obs_x(obs_x), .obs_y(obs_y),
    .obs_radius(obs_radius), .start_x(start_x), .start_y(start_y), .end_x(end_x),
    .end_y(end_y), .margin(margin_reg), .cur(cur), .px16(px), .py16(py)
  );

  // hold the hit fields for the result beat
  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      hx <= cur.x; hy <= cur.y; hr <= cur.r; cx <= px; cy <= py;
    end
  end
  assign hit_x      = hit_sel ? hx : '0;
  assign hit_y      = hit_sel ? hy : '0;
  assign hit_radius = hit_sel ? hr : '0;
  assign closest_x  = hit_sel ? cx : '0;
  assign closest_y  = hit_sel ? cy : '0;

  // checks
  a_no_take_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    table_count <= 9'(oscc_pkg::MAX_OBSTACLES)) else $error("table count overflow");
  a_hit_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == oscc_pkg::ST_HIT |-> hit_sel) else $error("hit without select");
endmodule
`default_nettype wire

FILE: test/tb_obstacle_segment_collision_check.sv
// testbench for the obstacle table segment collision check
`timescale 1ns / 1ps
module tb_obstacle_segment_collision_check;

  typedef struct {
    logic [1:0]         kind;
    logic signed [15:0] ox, oy;
    logic [14:0]        orad;
    logic [7:0]         ridx;
    logic signed [15:0] sx, sy, ex, ey;
  } beat_in_t;

  typedef struct {
    logic [1:0]         status;
    logic [7:0]         hit_index;
    logic signed [15:0] hit_x, hit_y;
    logic [14:0]        hit_radius;
    logic signed [15:0] closest_x, closest_y;
    logic [8:0]         table_count;
  } beat_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = '0;
  logic signed [15:0] obs_x = '0, obs_y = '0;
  logic [14:0] obs_radius = '0;
  logic [7:0] remove_index = '0;
  logic signed [15:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [7:0] hit_index;
  logic signed [15:0] hit_x, hit_y;
  logic [14:0] hit_radius;
  logic signed [15:0] closest_x, closest_y;
  logic [8:0] table_count;

  obstacle_segment_collision_check u_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  oscc_pkg::obstacle_t model_table [oscc_pkg::MAX_OBSTACLES];
  int          model_count;
  logic [14:0] model_margin;
  beat_out_t   expected_q[$];
  int          mismatches;
  int          results_seen;
  int          hits_seen;
  int          rejects_seen;

  // random gap, mostly short and sometimes long
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint floor_frac(longint p);
    return p >>> oscc_pkg::T_FRAC_BITS;
  endfunction

  // compute the result of one item and update the table
  function automatic beat_out_t predict_collision(beat_in_t b);
    beat_out_t r;
    longint sx, sy, abx, aby, len, dot, t, px, py, dx, dy, d2, lim;
    r = '{default: '0};
    case (b.kind)
      oscc_pkg::KIND_ADD: begin
        if (model_count >= oscc_pkg::MAX_OBSTACLES) r.status = oscc_pkg::ST_REJECT;
        else begin
          model_table[model_count] = '{x: b.ox, y: b.oy, r: b.orad};
          model_count++;
        end
      end
      oscc_pkg::KIND_REMOVE: begin
        if (int'(b.ridx) >= model_count) r.status = oscc_pkg::ST_REJECT;
        else begin
          for (int i = int'(b.ridx); i + 1 < model_count; i++)
            model_table[i] = model_table[i + 1];
          model_count--;
        end
      end
      oscc_pkg::KIND_CLEAR: model_count = 0;
      default: begin
        sx = b.sx; sy = b.sy;
        abx = longint'(b.ex) - sx;
        aby = longint'(b.ey) - sy;
        len = abx * abx + aby * aby;
        for (int i = 0; i < model_count; i++) begin
          px = sx; py = sy;
          if (len != 0) begin
            dot = (longint'(model_table[i].x) - sx) * abx
                + (longint'(model_table[i].y) - sy) * aby;
            if (dot <= 0) t = 0;
            else if (dot >= len) t = longint'(1) << oscc_pkg::T_FRAC_BITS;
            else t = (dot << oscc_pkg::T_FRAC_BITS) / len;
            px = sx + floor_frac(t * abx);
            py = sy + floor_frac(t * aby);
          end
          dx = px - model_table[i].x;
          dy = py - model_table[i].y;
          d2 = dx * dx + dy * dy;
          lim = longint'(model_table[i].r) + longint'(model_margin);
          if (d2 < lim * lim) begin
            r.status = oscc_pkg::ST_HIT;
            r.hit_index = 8'(i);
            r.hit_x = model_table[i].x;
            r.hit_y = model_table[i].y;
            r.hit_radius = model_table[i].r;
            r.closest_x = px[15:0];
            r.closest_y = py[15:0];
            break;
          end
        end
      end
    endcase
    r.table_count = 9'(model_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("MISMATCH result %0d %s: got %0d expected %0d", results_seen, what, got, want);
  endtask

  // send one beat, queue its expected result; valid stays up between back to back beats
  task automatic send_item(beat_in_t b);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= b.kind; obs_x <= b.ox; obs_y <= b.oy; obs_radius <= b.orad;
    remove_index <= b.ridx; start_x <= b.sx; start_y <= b.sy;
    end_x <= b.ex; end_y <= b.ey;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.insert(expected_q.size(), predict_collision(b));
  endtask

  // result checker and output stall
  always @(posedge clk) begin
    beat_out_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        e = expected_q.pop_front();
        if (status != e.status) report_mismatch("status", status, e.status);
        if (hit_index != e.hit_index) report_mismatch("hit_index", hit_index, e.hit_index);
        if (hit_x != e.hit_x) report_mismatch("hit_x", hit_x, e.hit_x);
        if (hit_y != e.hit_y) report_mismatch("hit_y", hit_y, e.hit_y);
        if (hit_radius != e.hit_radius) report_mismatch("hit_radius", hit_radius, e.hit_radius);
        if (closest_x != e.closest_x) report_mismatch("closest_x", closest_x, e.closest_x);
        if (closest_y != e.closest_y) report_mismatch("closest_y", closest_y, e.closest_y);
        if (table_count != e.table_count)
          report_mismatch("table_count", table_count, e.table_count);
        if (e.status == oscc_pkg::ST_HIT) hits_seen++;
        if (e.status == oscc_pkg::ST_REJECT) rejects_seen++;
      end
      results_seen++;
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= gap_len();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // register write while idle
  task automatic write_margin(logic [14:0] value);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 2'd0; pwdata <= {17'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    model_margin = value;
    @(posedge clk);
  endtask

  function automatic beat_in_t rand_beat(logic [1:0] k);
    beat_in_t b;
    b.kind = k;
    b.ox = 16'($urandom()); b.oy = 16'($urandom()); b.orad = 15'($urandom());
    b.ridx = 8'($urandom());
    b.sx = 16'($urandom()); b.sy = 16'($urandom());
    b.ex = 16'($urandom()); b.ey = 16'($urandom());
    return b;
  endfunction

  // coordinates clustered near the origin so that hits happen
  function automatic logic signed [15:0] near_coord(int span);
    return $signed(16'($urandom_range(0, 2 * span))) - 16'(span);
  endfunction

  function automatic beat_in_t local_beat(logic [1:0] k, int span);
    beat_in_t b;
    b = rand_beat(k);
    b.ox = near_coord(span); b.oy = near_coord(span);
    b.orad = 15'($urandom_range(0, span / 2));
    b.sx = near_coord(span); b.sy = near_coord(span);
    b.ex = near_coord(span); b.ey = near_coord(span);
    if ($urandom_range(0, 9) == 0) begin b.ex = b.sx; b.ey = b.sy; end
    b.ridx = 8'($urandom_range(0, 17));
    return b;
  endfunction

  task automatic test_directed_extremes();
    beat_in_t b;
    b = rand_beat(oscc_pkg::KIND_REMOVE); b.ridx = 0; send_item(b);   // remove from empty
    b = rand_beat(oscc_pkg::KIND_CLEAR); send_item(b);                 // clear when empty
    b = rand_beat(oscc_pkg::KIND_QUERY); send_item(b);                 // query on empty table
    b = '{oscc_pkg::KIND_ADD, 16'sh7fff, 16'sh7fff, 15'h7fff, 8'hff, '0, '0, '0, '0};
    send_item(b);
    b = '{oscc_pkg::KIND_ADD, -16'sh8000, -16'sh8000, 15'h0, 8'h00, '0, '0, '0, '0};
    send_item(b);
    b = '{oscc_pkg::KIND_ADD, 16'sh0, 16'sh0, 15'd100, 8'h00, '0, '0, '0, '0};
    send_item(b);
    // two extreme segments, then a zero-length segment and a short one
    b = '{oscc_pkg::KIND_QUERY, '0, '0, '0, '0, -16'sh8000, -16'sh8000, 16'sh7fff, 16'sh7fff};
    send_item(b);
    b = '{oscc_pkg::KIND_QUERY, '0, '0, '0, '0, 16'sh7fff, -16'sh8000, -16'sh8000, 16'sh7fff};
    send_item(b);
    b = '{oscc_pkg::KIND_QUERY, '0, '0, '0, '0, 16'sd10, 16'sd10, 16'sd10, 16'sd10};
    send_item(b);
    b = '{oscc_pkg::KIND_QUERY, '0, '0, '0, '0, -16'sd50, 16'sd3, 16'sd70, -16'sd9};
    send_item(b);
    b = rand_beat(oscc_pkg::KIND_REMOVE); b.ridx = 8'hff; send_item(b);   // bad index
    b = rand_beat(oscc_pkg::KIND_REMOVE); b.ridx = 3; send_item(b);       // index equal to count
    b = rand_beat(oscc_pkg::KIND_REMOVE); b.ridx = 0; send_item(b);       // remove front
    // fill to full, then one more add is rejected
    for (int i = 0; i < 15; i++) send_item(local_beat(oscc_pkg::KIND_ADD, 400));
    b = rand_beat(oscc_pkg::KIND_QUERY); send_item(b);
    b = rand_beat(oscc_pkg::KIND_REMOVE); b.ridx = 15; send_item(b);
    b = rand_beat(oscc_pkg::KIND_CLEAR); send_item(b);
  endtask

  task automatic test_margin_extremes();
    beat_in_t b;
    write_margin(15'h7fff);
    b = '{oscc_pkg::KIND_ADD, 16'sh7fff, -16'sh8000, 15'h7fff, 8'h00, '0, '0, '0, '0};
    send_item(b);
    b = '{oscc_pkg::KIND_QUERY, '0, '0, '0, '0, -16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff};
    send_item(b);
    b = '{oscc_pkg::KIND_QUERY, '0, '0, '0, '0, 16'sh0, 16'sh0, 16'sh7fff, -16'sh8000};
    send_item(b);
    b = rand_beat(oscc_pkg::KIND_CLEAR); send_item(b);
    wait_drained();
    write_margin(15'd0);
  endtask

  // well-formed add/query/remove mix with clears and some noise
  task automatic test_random_phase(int items, int span);
    int p;
    for (int i = 0; i < items; i++) begin
      p = $urandom_range(0, 99);
      if (p < 35) send_item(local_beat(oscc_pkg::KIND_ADD, span));
      else if (p < 80) send_item(local_beat(oscc_pkg::KIND_QUERY, span));
      else if (p < 92) send_item(local_beat(oscc_pkg::KIND_REMOVE, span));
      else if (p < 95) send_item(rand_beat(oscc_pkg::KIND_CLEAR));
      else send_item(rand_beat(2'($urandom_range(0, 3))));
    end
    wait_drained();
  endtask

  initial begin
    model_count = 0; model_margin = '0; mismatches = 0;
    results_seen = 0; hits_seen = 0; rejects_seen = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    wait_drained();
    test_margin_extremes();
    test_random_phase(400, 300);
    write_margin(15'd40);
    test_random_phase(400, 2000);
    write_margin(15'($urandom_range(0, 32767)));
    test_random_phase(400, 32767);
    write_margin(15'd0);
    test_random_phase(400, 120);
    $display("covered %0d results: %0d hits, %0d rejects, margin extremes and random settings",
             results_seen, hits_seen, rejects_seen);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #100ms;
    $display("Mismatches found");
    $finish;
  end
endmodule

FILE: filelist.f
design/oscc_pkg.sv
design/oscc_div.sv
design/oscc_datapath.sv
design/oscc_ctrl.sv
design/obstacle_segment_collision_check.sv
test/tb_obstacle_segment_collision_check.sv
